// ----- sv/dah_pkg.sv -----
package dah_pkg;

  localparam int unsigned CAPACITY_DEF  = 1024;
  localparam int unsigned MAX_ARITY_DEF = 8;

  localparam int unsigned ActW  = 3;
  localparam int unsigned PosW  = 10;
  localparam int unsigned WW    = 32;
  localparam int unsigned CntW  = 11;
  localparam int unsigned StW   = 2;
  localparam int unsigned ArW   = 4;

  typedef enum logic [2:0] {
    ACT_LOAD    = 3'd0,
    ACT_BUILD   = 3'd1,
    ACT_DEC     = 3'd2,
    ACT_DELMIN  = 3'd3,
    ACT_DELPOS  = 3'd4,
    ACT_CLEAR   = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_DEC_RD,
    S_DEC_WR,
    S_UP_RD_CUR,
    S_UP_RD_PAR,
    S_UP_CMP,
    S_UP_SWAP,
    S_DN_START,
    S_DN_RD_CUR,
    S_DN_RD_CH,
    S_DN_SCAN,
    S_DN_SWAP,
    S_RM_RD_ROOT,
    S_RM_RD_LAST,
    S_RM_WR,
    S_BUILD_NEXT,
    S_ROOT_RD,
    S_ROOT_WAIT,
    S_OUT
  } state_e;

  // Controller commands and datapath status
  typedef struct packed {
    logic latch_in;      // capture request fields
    logic rd_cur;        // read mem at cur
    logic rd_par;        // read mem at parent
    logic rd_ch;         // read mem at child index
    logic rd_root;       // read mem at 0
    logic rd_last;       // read mem at size-1
    logic cap_cur;       // capture read data as cur weight
    logic cap_oth;       // capture read data as other weight
    logic cap_best;      // capture read data as best (first child)
    logic scan_cmp;      // compare read data with best
    logic ch_inc;        // advance child index
    logic dn_init;       // set first/last child from cur
    logic wr_dec;        // write saturated value at cur
    logic swap_a;        // write oth weight at cur
    logic swap_b;        // write cur weight at partner
    logic move_up;       // cur <= parent
    logic move_dn;       // cur <= best
    logic set_cur_pos;   // cur <= position
    logic set_cur_zero;  // cur <= 0
    logic set_cur_bld;   // cur <= build index
    logic bld_init;      // build index <= size
    logic bld_dec;       // build index--
    logic append;        // write weight_in, size++
    logic clear;         // size <= 0
    logic rm_wr;         // write last at root, size--
    logic cap_removed;   // removed <= cur weight
    logic cap_root;      // root output <= read data
    logic set_status;
    status_e status;
  } cmd_t;

  typedef struct packed {
    action_e action;
    logic    empty;
    logic    full;
    logic    badpos;
    logic    dec_up;       // delta > 0
    logic    cur_zero;
    logic    up_less;      // cur < parent
    logic    has_child;    // first child < size
    logic    ch_more;      // another child to scan
    logic    dn_swap;      // cur > best
    logic    bld_zero;
  } sts_t;

endpackage

// ----- sv/dah_datapath.sv -----
module dah_datapath
  import dah_pkg::*;
#(
  parameter int unsigned CAPACITY  = CAPACITY_DEF,
  parameter int unsigned MAX_ARITY = MAX_ARITY_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [ArW-1:0]        cfg_wdata_i,
  input  logic [ActW-1:0]       action_i,
  input  logic [PosW-1:0]       position_i,
  input  logic signed [WW-1:0]  delta_i,
  input  logic signed [WW-1:0]  weight_in_i,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  output logic signed [WW-1:0]  removed_weight_o,
  output logic signed [WW-1:0]  root_weight_o,
  output logic [CntW-1:0]       heap_count_o,
  output logic [StW-1:0]        status_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned SW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = SW + 5;

  logic signed [WW-1:0] mem_q [CAPACITY];
  logic signed [WW-1:0] rd_q;

  logic [ArW-1:0]       arity_q;
  logic [SW-1:0]        size_q;
  logic [AW-1:0]        cur_q, best_q, par_q;
  logic [SW-1:0]        bld_q;
  logic [XW-1:0]        ch_q, last_q;
  logic signed [WW-1:0] wcur_q, woth_q, wbest_q, removed_q, root_q;
  logic [ActW-1:0]      act_q;
  logic [PosW-1:0]      pos_q;
  logic signed [WW-1:0] delta_q, win_q;
  status_e              status_q;

  logic [ArW-1:0] d_eff;
  always_comb begin
    if (arity_q < ArW'(2)) d_eff = ArW'(2);
    else if (32'(arity_q) > MAX_ARITY) d_eff = ArW'(MAX_ARITY);
    else d_eff = arity_q;
  end

  logic [XW-1:0] first_x, last_x, size_x;
  assign size_x  = XW'(size_q);
  assign first_x = XW'(cur_q) * XW'(d_eff) + XW'(1);
  always_comb begin
    last_x = first_x + XW'(d_eff) - XW'(1);
    if (last_x > size_x - XW'(1)) last_x = size_x - XW'(1);
  end

  logic signed [WW:0] dec_v;
  logic signed [WW-1:0] dec_sat;
  always_comb begin
    dec_v = {rd_q[WW-1], rd_q} - {delta_q[WW-1], delta_q};
    if (dec_v[WW] != dec_v[WW-1])
      dec_sat = dec_v[WW] ? {1'b1, {(WW-1){1'b0}}} : {1'b0, {(WW-1){1'b1}}};
    else
      dec_sat = dec_v[WW-1:0];
  end

  // parent = (cur-1)/d by multiplying with a rounded-up reciprocal of d,
  // then one correction step
  localparam int unsigned RF = AW + 5;
  logic [RF-1:0] recip;
  always_comb begin
    recip = '0;
    for (int k = 2; k <= 16; k++)
      if (32'(d_eff) == k) recip = RF'(((64'(1) << RF) + 64'(k) - 1) / 64'(k));
  end
  logic [AW-1:0]      cm1;
  logic [AW+RF-1:0]   prod;
  logic [AW-1:0]      qest;
  logic [AW+ArW:0]    qchk;
  assign cm1  = cur_q - AW'(1);
  assign prod = (AW+RF)'(cm1) * (AW+RF)'(recip);
  always_comb begin
    qest = AW'(prod >> RF);
    qchk = (AW+ArW+1)'(qest) * (AW+ArW+1)'(d_eff);
    if (qchk > (AW+ArW+1)'(cm1)) qest = qest - AW'(1);
  end

  // status to controller
  always_comb begin
    sts_o.action    = action_e'(act_q);
    sts_o.empty     = (size_q == '0);
    sts_o.full      = (32'(size_q) >= CAPACITY);
    sts_o.badpos    = (SW'(pos_q) >= size_q) || (32'(pos_q) >= CAPACITY);
    sts_o.dec_up    = !delta_q[WW-1] && (delta_q != '0);
    sts_o.cur_zero  = (cur_q == '0);
    sts_o.up_less   = wcur_q < rd_q;
    sts_o.has_child = first_x < size_x;
    sts_o.ch_more   = ch_q <= last_q;
    sts_o.dn_swap   = wcur_q > wbest_q;
    sts_o.bld_zero  = (bld_q == '0);
  end

  logic [AW-1:0] rd_addr;
  always_comb begin
    rd_addr = cur_q;
    if (cmd_i.rd_par)  rd_addr = par_q;
    if (cmd_i.rd_ch)   rd_addr = ch_q[AW-1:0];
    if (cmd_i.rd_root) rd_addr = '0;
    if (cmd_i.rd_last) rd_addr = AW'(size_q - SW'(1));
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[rd_addr];
    if (cmd_i.append)     mem_q[AW'(size_q)] <= win_q;
    if (cmd_i.wr_dec)     mem_q[cur_q] <= dec_sat;
    if (cmd_i.swap_a)     mem_q[cur_q] <= woth_q;
    if (cmd_i.swap_b)     mem_q[best_q] <= wcur_q;
    if (cmd_i.rm_wr)      mem_q[0] <= rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arity_q  <= ArW'(2);
      size_q   <= '0;
      status_q <= ST_OK;
    end else begin
      if (cfg_we_i) arity_q <= cfg_wdata_i;
      if (cmd_i.append) size_q <= size_q + SW'(1);
      if (cmd_i.rm_wr)  size_q <= size_q - SW'(1);
      if (cmd_i.clear)  size_q <= '0;
      if (cmd_i.latch_in) status_q <= ST_OK;
      if (cmd_i.set_status) status_q <= cmd_i.status;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      act_q <= action_i; pos_q <= position_i;
      delta_q <= delta_i; win_q <= weight_in_i;
      removed_q <= '0;
    end
    if (cmd_i.set_cur_pos)  cur_q <= AW'(pos_q);
    if (cmd_i.set_cur_zero) cur_q <= '0;
    if (cmd_i.set_cur_bld)  cur_q <= AW'(bld_q - SW'(1));
    if (cmd_i.move_up)      cur_q <= par_q;
    if (cmd_i.move_dn)      cur_q <= best_q;
    if (cmd_i.rd_cur)       par_q <= qest;
    if (cmd_i.rd_par)       best_q <= par_q;
    if (cmd_i.cap_cur)      wcur_q <= cmd_i.wr_dec ? dec_sat : rd_q;
    if (cmd_i.wr_dec)       wcur_q <= dec_sat;
    if (cmd_i.cap_oth)      woth_q <= rd_q;
    if (cmd_i.dn_init) begin
      ch_q <= first_x; last_q <= last_x;
      best_q <= AW'(first_x);
    end
    if (cmd_i.cap_best)     begin wbest_q <= rd_q; woth_q <= rd_q; end
    // read data belongs to the child before the current scan index
    if (cmd_i.scan_cmp && (rd_q < wbest_q)) begin
      wbest_q <= rd_q; woth_q <= rd_q; best_q <= ch_q[AW-1:0] - AW'(1);
    end
    if (cmd_i.ch_inc)       ch_q <= ch_q + XW'(1);
    if (cmd_i.bld_init)     bld_q <= size_q;
    if (cmd_i.bld_dec)      bld_q <= bld_q - SW'(1);
    if (cmd_i.cap_removed)  removed_q <= wcur_q;
    if (cmd_i.cap_root)     root_q <= (size_q == '0) ? '0 : rd_q;
  end

  assign removed_weight_o = removed_q;
  assign root_weight_o    = root_q;
  assign heap_count_o     = CntW'(size_q);
  assign status_o         = status_q;

endmodule

// ----- sv/dah_ctrl.sv -----
module dah_ctrl
  import dah_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   bld_q, bld_d;   // sift-down runs inside build
  logic   del_q, del_d;   // sift-up runs for delete at position

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; bld_q <= 1'b0; del_q <= 1'b0;
    end else begin
      state_q <= state_d; bld_q <= bld_d; del_q <= del_d;
    end
  end

  always_comb begin
    state_d = state_q;
    bld_d = bld_q;
    del_d = del_q;
    cmd_o = '0;
    cmd_o.status = ST_OK;
    in_stall_o = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        bld_d = 1'b0; del_d = 1'b0;
        state_d = S_ROOT_RD;
        case (sts_i.action)
          ACT_LOAD: begin
            if (sts_i.full) begin
              cmd_o.set_status = 1'b1; cmd_o.status = ST_FULL;
            end else cmd_o.append = 1'b1;
          end
          ACT_BUILD: begin
            cmd_o.bld_init = 1'b1; bld_d = 1'b1;
            state_d = S_BUILD_NEXT;
          end
          ACT_DEC, ACT_DELPOS: begin
            if (sts_i.empty) begin
              cmd_o.set_status = 1'b1; cmd_o.status = ST_EMPTY;
            end else if (sts_i.badpos) begin
              cmd_o.set_status = 1'b1; cmd_o.status = ST_BADPOS;
            end else begin
              cmd_o.set_cur_pos = 1'b1;
              del_d = (sts_i.action == ACT_DELPOS);
              state_d = S_DEC_RD;
            end
          end
          ACT_DELMIN: begin
            if (sts_i.empty) begin
              cmd_o.set_status = 1'b1; cmd_o.status = ST_EMPTY;
            end else state_d = S_RM_RD_ROOT;
          end
          ACT_CLEAR: cmd_o.clear = 1'b1;
          default: ;
        endcase
      end
      S_DEC_RD: begin
        cmd_o.rd_cur = 1'b1;
        state_d = S_DEC_WR;
      end
      S_DEC_WR: begin
        if (del_q) begin
          cmd_o.cap_cur = 1'b1;
          state_d = S_UP_RD_CUR;
        end else begin
          cmd_o.wr_dec = 1'b1;
          state_d = sts_i.dec_up ? S_UP_RD_CUR : S_DN_START;
        end
      end
      S_UP_RD_CUR: begin
        if (sts_i.cur_zero) begin
          state_d = del_q ? S_RM_RD_ROOT : S_ROOT_RD;
          if (del_q) cmd_o.cap_removed = 1'b1;
        end else begin
          cmd_o.rd_cur = 1'b1;   // computes parent
          state_d = S_UP_RD_PAR;
        end
      end
      S_UP_RD_PAR: begin
        cmd_o.rd_par = 1'b1;
        state_d = S_UP_CMP;
      end
      S_UP_CMP: begin
        cmd_o.cap_oth = 1'b1;
        if (del_q || sts_i.up_less) state_d = S_UP_SWAP;
        else state_d = S_ROOT_RD;
      end
      S_UP_SWAP: begin
        cmd_o.swap_a = 1'b1; cmd_o.swap_b = 1'b1; cmd_o.move_up = 1'b1;
        state_d = S_UP_RD_CUR;
      end
      S_DN_START: begin
        if (sts_i.has_child) begin
          cmd_o.dn_init = 1'b1; cmd_o.rd_cur = 1'b1;
          state_d = S_DN_RD_CUR;
        end else state_d = bld_q ? S_BUILD_NEXT : S_ROOT_RD;
      end
      S_DN_RD_CUR: begin
        cmd_o.cap_cur = 1'b1; cmd_o.rd_ch = 1'b1; cmd_o.ch_inc = 1'b1;
        state_d = S_DN_RD_CH;
      end
      S_DN_RD_CH: begin
        cmd_o.cap_best = 1'b1;
        if (sts_i.ch_more) begin
          cmd_o.rd_ch = 1'b1; cmd_o.ch_inc = 1'b1;
          state_d = S_DN_SCAN;
        end else state_d = S_DN_SWAP;
      end
      S_DN_SCAN: begin
        cmd_o.scan_cmp = 1'b1;
        if (sts_i.ch_more) begin
          cmd_o.rd_ch = 1'b1; cmd_o.ch_inc = 1'b1;
        end else state_d = S_DN_SWAP;
      end
      S_DN_SWAP: begin
        if (sts_i.dn_swap) begin
          cmd_o.swap_a = 1'b1; cmd_o.swap_b = 1'b1; cmd_o.move_dn = 1'b1;
          state_d = S_DN_START;
        end else state_d = bld_q ? S_BUILD_NEXT : S_ROOT_RD;
      end
      S_RM_RD_ROOT: begin
        cmd_o.rd_root = 1'b1;
        state_d = S_RM_RD_LAST;
      end
      S_RM_RD_LAST: begin
        if (!del_q) cmd_o.cap_cur = 1'b1;
        cmd_o.rd_last = 1'b1;
        state_d = S_RM_WR;
      end
      S_RM_WR: begin
        if (!del_q) cmd_o.cap_removed = 1'b1;
        cmd_o.rm_wr = 1'b1; cmd_o.set_cur_zero = 1'b1;
        state_d = S_DN_START;
      end
      S_BUILD_NEXT: begin
        if (sts_i.bld_zero) state_d = S_ROOT_RD;
        else begin
          // step the build index down and sift from it
          cmd_o.bld_dec = 1'b1; cmd_o.set_cur_bld = 1'b1;
          state_d = S_DN_START;
        end
      end
      S_ROOT_RD: begin
        cmd_o.rd_root = 1'b1;
        state_d = S_ROOT_WAIT;
      end
      S_ROOT_WAIT: begin
        cmd_o.cap_root = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ----- sv/d_ary_min_heap.sv -----
// d-ary min-heap of signed 32-bit weights in a memory with one registered
// read port and two write ports. One request is handled at a time and yields one result.
// Load, clear and rejected requests go straight to the root read; sift-up
// reads, compares and swaps per level, sift-down scans every child per level, and build
// runs a sift-down at every entry, so it scales with the entry count.
module d_ary_min_heap
  import dah_pkg::*;
#(
  parameter int unsigned CAPACITY  = CAPACITY_DEF,
  parameter int unsigned MAX_ARITY = MAX_ARITY_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [ArW-1:0]       cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [ActW-1:0]      action_i,
  input  logic [PosW-1:0]      position_i,
  input  logic signed [WW-1:0] delta_i,
  input  logic signed [WW-1:0] weight_in_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [WW-1:0] removed_weight_o,
  output logic signed [WW-1:0] root_weight_o,
  output logic [CntW-1:0]      heap_count_o,
  output logic [StW-1:0]       status_o
);

  cmd_t cmd;
  sts_t sts;

  dah_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  dah_datapath #(.CAPACITY(CAPACITY), .MAX_ARITY(MAX_ARITY)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .action_i, .position_i,
    .delta_i, .weight_in_i, .cmd_i(cmd), .sts_o(sts),
    .removed_weight_o, .root_weight_o, .heap_count_o, .status_o
  );

endmodule

// ----- sv/dah_checker.sv -----
module dah_checker
  import dah_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_stall_o,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input logic [CntW-1:0] heap_count_o,
  input logic [StW-1:0]  status_o
);

  // a result stays up while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(heap_count_o) && $stable(status_o))
    else $error("result dropped while stalled");

  // no new request while a result waits
  a_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("request taken while result pending");

  // accepted request never gives a result next cycle
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !out_valid_o)
    else $error("result too early");

endmodule

bind d_ary_min_heap dah_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .heap_count_o, .status_o
);

// ----- verif/d_ary_min_heap_tb.sv -----
module d_ary_min_heap_tb;
  import dah_pkg::*;

  localparam int unsigned HeapCap = CAPACITY_DEF;
  localparam logic [ActW-1:0] ACT_SPARE_LO = 3'd6;
  localparam logic [ActW-1:0] ACT_SPARE_HI = 3'd7;
  localparam logic signed [WW-1:0] W_MAX = 32'sh7fffffff;
  localparam logic signed [WW-1:0] W_MIN = 32'sh80000000;

  typedef struct {
    logic signed [WW-1:0] removed;
    logic signed [WW-1:0] root;
    logic [CntW-1:0]      count;
    status_e              status;
  } heap_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [ArW-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [ActW-1:0] action_i = '0;
  logic [PosW-1:0] position_i = '0;
  logic signed [WW-1:0] delta_i = '0;
  logic signed [WW-1:0] weight_in_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [WW-1:0] removed_weight_o;
  logic signed [WW-1:0] root_weight_o;
  logic [CntW-1:0] heap_count_o;
  logic [StW-1:0] status_o;

  d_ary_min_heap dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o,
    .action_i, .position_i, .delta_i, .weight_in_i, .out_valid_o, .out_stall_i,
    .removed_weight_o, .root_weight_o, .heap_count_o, .status_o
  );

  always #5 clk_i = ~clk_i;

  // Shadow heap
  logic signed [WW-1:0] heap_mem [HeapCap];
  int unsigned heap_len;
  logic [ArW-1:0] arity_reg;
  heap_result_t pending_results[$];

  int unsigned errors;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_left;

  function automatic int unsigned eff_arity();
    if (arity_reg < 2) return 2;
    if (arity_reg > MAX_ARITY_DEF) return MAX_ARITY_DEF;
    return int'(arity_reg);
  endfunction

  function automatic void swap_entries(int unsigned a, int unsigned b);
    logic signed [WW-1:0] t;
    t = heap_mem[a];
    heap_mem[a] = heap_mem[b];
    heap_mem[b] = t;
  endfunction

  function automatic void sink(int unsigned node);
    int unsigned d, cur, first, last, best;
    d = eff_arity();
    cur = node;
    forever begin
      first = cur * d + 1;
      if (first >= heap_len) return;
      last = first + d - 1;
      if (last > heap_len - 1) last = heap_len - 1;
      best = first;
      for (int unsigned i = first + 1; i <= last; i++)
        if (heap_mem[i] < heap_mem[best]) best = i;
      if (!(heap_mem[cur] > heap_mem[best])) return;
      swap_entries(cur, best);
      cur = best;
    end
  endfunction

  function automatic void rise(int unsigned node, bit to_root);
    int unsigned d, cur, par;
    d = eff_arity();
    cur = node;
    while (cur != 0) begin
      par = (cur - 1) / d;
      if (!to_root && !(heap_mem[cur] < heap_mem[par])) return;
      swap_entries(cur, par);
      cur = par;
    end
  endfunction

  function automatic logic signed [WW-1:0] pop_root();
    logic signed [WW-1:0] w;
    w = heap_mem[0];
    swap_entries(0, heap_len - 1);
    heap_len--;
    sink(0);
    return w;
  endfunction

  function automatic heap_result_t apply_request(logic [ActW-1:0] act, logic [PosW-1:0] pos,
                                                 logic signed [WW-1:0] delta,
                                                 logic signed [WW-1:0] win);
    heap_result_t r;
    logic signed [WW:0] v;
    r.removed = '0;
    r.status = ST_OK;
    case (act)
      ACT_LOAD: begin
        if (heap_len >= HeapCap) r.status = ST_FULL;
        else begin
          heap_mem[heap_len] = win;
          heap_len++;
        end
      end
      ACT_BUILD: for (int i = int'(heap_len) - 1; i >= 0; i--) sink(i);
      ACT_DEC: begin
        if (heap_len == 0) r.status = ST_EMPTY;
        else if (pos >= heap_len) r.status = ST_BADPOS;
        else begin
          v = {heap_mem[pos][WW-1], heap_mem[pos]} - {delta[WW-1], delta};
          if (v < $signed({W_MIN[WW-1], W_MIN})) v = {W_MIN[WW-1], W_MIN};
          if (v > $signed({1'b0, W_MAX})) v = {1'b0, W_MAX};
          heap_mem[pos] = v[WW-1:0];
          if (delta > 0) rise(pos, 1'b0);
          else sink(pos);
        end
      end
      ACT_DELMIN: begin
        if (heap_len == 0) r.status = ST_EMPTY;
        else r.removed = pop_root();
      end
      ACT_DELPOS: begin
        if (heap_len == 0) r.status = ST_EMPTY;
        else if (pos >= heap_len) r.status = ST_BADPOS;
        else begin
          r.removed = heap_mem[pos];
          rise(pos, 1'b1);
          void'(pop_root());
        end
      end
      ACT_CLEAR: heap_len = 0;
      default: ;
    endcase
    r.root = (heap_len > 0) ? heap_mem[0] : '0;
    r.count = heap_len[CntW-1:0];
    return r;
  endfunction

  // Receiver: random stall, or a long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    heap_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: removed=%0d root=%0d count=%0d status=%0d",
               removed_weight_o, root_weight_o, heap_count_o, status_o);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (removed_weight_o !== e.removed) begin
          $error("removed_weight: expected %0d, got %0d", e.removed, removed_weight_o);
          errors++;
        end
        if (root_weight_o !== e.root) begin
          $error("root_weight: expected %0d, got %0d", e.root, root_weight_o);
          errors++;
        end
        if (heap_count_o !== e.count) begin
          $error("heap_count: expected %0d, got %0d", e.count, heap_count_o);
          errors++;
        end
        if (status_o !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, status_o);
          errors++;
        end
      end
    end
  end

  task automatic send_request(logic [ActW-1:0] act, logic [PosW-1:0] pos,
                              logic signed [WW-1:0] delta, logic signed [WW-1:0] win);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    action_i <= act;
    position_i <= pos;
    delta_i <= delta;
    weight_in_i <= win;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(apply_request(act, pos, delta, win));
  endtask

  // Hold the sender until every result is back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_arity(logic [ArW-1:0] a);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= a;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    arity_reg = a;
  endtask

  function automatic logic signed [WW-1:0] rand_weight();
    case ($urandom_range(9))
      0: return W_MAX;
      1: return W_MIN;
      2, 3: return $urandom();
      default: return $signed(32'($urandom_range(200))) - 100;
    endcase
  endfunction

  task automatic test_directed();
    send_request(ACT_DELMIN, '0, '0, '0);
    send_request(ACT_DEC, '0, 5, '0);
    send_request(ACT_DELPOS, '0, '0, '0);
    send_request(ACT_BUILD, '0, '0, '0);
    send_request(ACT_LOAD, '0, '0, W_MAX);
    send_request(ACT_LOAD, '0, '0, W_MIN);
    send_request(ACT_LOAD, '0, '0, 32'sd0);
    send_request(ACT_LOAD, '0, '0, -32'sd1);
    send_request(ACT_LOAD, '0, '0, 32'sd7);
    send_request(ACT_LOAD, '0, '0, 32'sd7);
    send_request(ACT_BUILD, '0, '0, '0);
    send_request(ACT_DEC, 10'd1023, 3, '0);
    send_request(ACT_DELPOS, 10'd6, '0, '0);
    send_request(ACT_DEC, 10'd5, W_MAX, '0);
    send_request(ACT_DEC, 10'd3, W_MIN, '0);
    send_request(ACT_DEC, 10'd2, '0, '0);
    send_request(ACT_DEC, 10'd4, -32'sd50, '0);
    send_request(ACT_DELPOS, 10'd5, '0, '0);
    send_request(ACT_DELPOS, 10'd0, '0, '0);
    send_request(ACT_DELMIN, '0, '0, '0);
    send_request(ACT_SPARE_LO, 10'h3ff, W_MIN, W_MAX);
    send_request(ACT_SPARE_HI, 10'h155, -32'sd1, -32'sd1);
    send_request(ACT_CLEAR, '0, '0, '0);
    send_request(ACT_DELMIN, '0, '0, '0);
  endtask

  task automatic test_full();
    for (int i = 0; i < HeapCap; i++) send_request(ACT_LOAD, '0, '0, rand_weight());
    send_request(ACT_LOAD, '0, '0, 32'sd1);
    send_request(ACT_DELPOS, 10'd1023, '0, '0);
    send_request(ACT_CLEAR, '0, '0, '0);
  endtask

  task automatic test_backpressure();
    drain();
    hold_left = 400;
    for (int i = 0; i < 20; i++) send_request(ACT_LOAD, '0, '0, rand_weight());
    drain();
    send_request(ACT_BUILD, '0, '0, '0);
  endtask

  task automatic test_random(int unsigned n);
    int unsigned k;
    logic [PosW-1:0] pos;
    logic signed [WW-1:0] delta;
    for (int unsigned i = 0; i < n; i++) begin
      k = $urandom_range(99);
      pos = (heap_len > 0 && $urandom_range(9) != 0) ? PosW'($urandom_range(heap_len - 1))
                                                       : PosW'($urandom());
      case ($urandom_range(3))
        0: delta = $urandom();
        1: delta = $urandom_range(1) ? W_MAX : W_MIN;
        default: delta = $signed(32'($urandom_range(60))) - 30;
      endcase
      if (k < 35 && heap_len < 60) send_request(ACT_LOAD, PosW'($urandom()), delta,
                                                rand_weight());
      else if (k < 45) send_request(ACT_BUILD, pos, delta, rand_weight());
      else if (k < 65) send_request(ACT_DEC, pos, delta, rand_weight());
      else if (k < 80) send_request(ACT_DELMIN, pos, delta, rand_weight());
      else if (k < 95) send_request(ACT_DELPOS, pos, delta, rand_weight());
      else if (k < 97) send_request(ACT_CLEAR, pos, delta, rand_weight());
      else if (k < 99) send_request($urandom_range(1) ? ACT_SPARE_LO : ACT_SPARE_HI, pos,
                                    delta, rand_weight());
      else send_request(ACT_DELMIN, pos, delta, rand_weight());
    end
  endtask

  initial begin
    heap_len = 0;
    arity_reg = 4'd2;
    errors = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    write_arity(4'd8);
    test_directed();
    test_full();
    test_backpressure();

    write_arity(4'd3);
    test_random(100);
    write_arity(4'd0);
    send_idle_pct = 51;
    test_random(100);
    write_arity(4'd15);
    send_idle_pct = 0;
    recv_stall_pct = 51;
    test_random(100);
    write_arity(4'd1);
    send_idle_pct = 25;
    recv_stall_pct = 25;
    test_random(50);
    write_arity(4'd5);
    test_random(50);
    write_arity(4'd9);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random(50);

    drain();
    repeat (50) @(posedge clk_i);
    if (errors == 0) $display("[d_ary_min_heap] OK");
    else $display("[d_ary_min_heap] ERROR");
    $finish;
  end

  initial begin
    #20000000;
    $display("[d_ary_min_heap] ERROR");
    $finish;
  end

endmodule
